// File: hw/rtl/lxsr_pkg.sv
// ----------------------------------------------------------------------------
// lxsr_pkg
// Shared types and constants of the lagged XOR shift register generator.
// ----------------------------------------------------------------------------
package lxsr_pkg;

  localparam int WORD_W = 31;
  localparam int MULT_W = 15;

  localparam logic [MULT_W-1:0] LEHMER_MULT = 15'd16807;
  localparam logic [WORD_W-1:0] SEED_RESET  = 31'd1;

  localparam logic FUNC_RESEED = 1'b0;
  localparam logic FUNC_DRAW   = 1'b1;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] scale_limit;
  } lxsr_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] random_word;
    logic [WORD_W-1:0] scaled_value;
  } lxsr_result_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] limit;
  } lxsr_req_t;

endpackage

// File: hw/rtl/lxsr_table.sv
// ----------------------------------------------------------------------------
// lxsr_table
// Word table: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module lxsr_table #(
  parameter int DEPTH = 251,
  parameter int AW    = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr_a,
  input  logic [AW-1:0]            rd_addr_b,
  output logic [lxsr_pkg::WORD_W-1:0] rd_data_a,
  output logic [lxsr_pkg::WORD_W-1:0] rd_data_b,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [lxsr_pkg::WORD_W-1:0] wr_data
);
  import lxsr_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// File: hw/rtl/lxsr_scale.sv
// ----------------------------------------------------------------------------
// lxsr_scale
// Scales a new word by the draw limit and holds the result transaction.
// ----------------------------------------------------------------------------
module lxsr_scale (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  lxsr_pkg::lxsr_req_t    req,
  output logic                   busy,
  output logic                   result_valid,
  input  logic                   result_stall,
  output lxsr_pkg::lxsr_result_t result
);
  import lxsr_pkg::*;

  logic                  pend;
  lxsr_req_t             pend_req;
  logic [2*WORD_W-1:0]   prod;
  logic                  advance;

  assign prod    = (2*WORD_W)'(pend_req.word) * (2*WORD_W)'(pend_req.limit);
  assign advance = pend && (!result_valid || !result_stall);
  assign busy    = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (go) begin
        pend <= 1'b1;
      end else if (advance) begin
        pend <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      pend_req <= req;
    end
    if (advance) begin
      result.random_word  <= pend_req.word;
      result.scaled_value <= prod[2*WORD_W-1:WORD_W];
    end
  end

endmodule

// File: hw/rtl/lagged_xor_shift_register_rng.sv
// ----------------------------------------------------------------------------
// lagged_xor_shift_register_rng
// Lagged XOR feedback shift register generator over a word table.
//
//   channel   signals                              direction
//   item      item_valid, item_stall, item         in
//   result    result_valid, result_stall, result   out
//   seed      seed_wr_en, seed_wr_data             in
//
// A draw reaches the result register through table read, XOR and write back,
// then the scaling multiply; the next item is taken once the scaling stage has
// passed the draw on. A reseed writes one table word per cycle, TABLE_LENGTH
// words in all, and takes no item until the last one. A stalled result holds in
// the result register and blocks the hand-off of the following draw. rst is
// synchronous; it clears pointer and sequence word, sets seed to 1, not table.
// ----------------------------------------------------------------------------
module lagged_xor_shift_register_rng #(
  parameter int TABLE_LENGTH = 251,
  parameter int TAP_OFFSET   = 147
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  lxsr_pkg::lxsr_item_t          item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output lxsr_pkg::lxsr_result_t        result,
  input  logic                          seed_wr_en,
  input  logic [lxsr_pkg::WORD_W-1:0]   seed_wr_data
);
  import lxsr_pkg::*;

  localparam int AW = $clog2(TABLE_LENGTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_LENGTH - 1);
  localparam logic [AW:0]   TAP      = (AW+1)'(TAP_OFFSET);
  localparam logic [AW:0]   LEN      = (AW+1)'(TABLE_LENGTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_XOR  = 2'd2;

  logic [1:0]          state;
  logic [AW-1:0]       pointer;
  logic [AW-1:0]       fill_cnt;
  logic [WORD_W-1:0]   seed;
  logic [WORD_W-1:0]   lehmer;
  logic [WORD_W-1:0]   lehmer_next;
  logic [WORD_W-1:0]   limit;
  logic [WORD_W+MULT_W-1:0] lehmer_prod;
  logic [AW:0]         tap_sum;
  logic [AW-1:0]       tap_addr;
  logic                accept;
  logic                scale_busy;
  logic                go;
  lxsr_req_t           req;
  logic [WORD_W-1:0]   rd_data_a;
  logic [WORD_W-1:0]   rd_data_b;
  logic [WORD_W-1:0]   xor_word;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [WORD_W-1:0]   wr_data;

  assign item_stall = (state != ST_IDLE) || scale_busy;
  assign accept     = item_valid && !item_stall;

  assign lehmer_prod = (WORD_W+MULT_W)'(lehmer) * (WORD_W+MULT_W)'(LEHMER_MULT);
  assign lehmer_next = lehmer_prod[WORD_W-1:0];

  assign tap_sum  = {1'b0, pointer} + TAP;
  assign tap_addr = (tap_sum >= LEN) ? AW'(tap_sum - LEN) : tap_sum[AW-1:0];

  assign xor_word = rd_data_a ^ rd_data_b;
  assign go       = (state == ST_XOR);
  assign req      = '{word: xor_word, limit: limit};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pointer;
    wr_data = xor_word;
    unique case (state)
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = fill_cnt;
        wr_data = lehmer_next;
      end
      ST_XOR: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pointer  <= '0;
      fill_cnt <= '0;
      seed     <= SEED_RESET;
      lehmer   <= '0;
    end else begin
      if (seed_wr_en) begin
        seed <= seed_wr_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (item.func == FUNC_RESEED) begin
              lehmer   <= seed;
              fill_cnt <= '0;
              pointer  <= '0;
              state    <= ST_FILL;
            end else begin
              state <= ST_XOR;
            end
          end
        end
        ST_FILL: begin
          lehmer   <= lehmer_next;
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_cnt == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_XOR: begin
          pointer <= (pointer == LAST_IDX) ? '0 : pointer + 1'b1;
          state   <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      limit <= item.scale_limit;
    end
  end

  lxsr_table #(
    .DEPTH (TABLE_LENGTH),
    .AW    (AW)
  ) u_table (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a (pointer),
    .rd_addr_b (tap_addr),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  lxsr_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .req          (req),
    .busy         (scale_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: verif/lagged_xor_shift_register_rng_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_xor_shift_register_rng_test
// Self-checking bench for the lagged XOR shift register generator.
//
// A tracker class keeps its own word table, pointer and Lehmer word. It
// predicts every draw from the transactions the block accepts, and it checks
// each result transaction in order, field by field. A directed opening covers
// the reset seed, seeds of zero and all ones, and scale limits at both ends.
// Random phases follow, each with a new seed and its own mix of sender idling
// and receiver stalls, with draws and occasional reseeds.
// ----------------------------------------------------------------------------

class gfsr_tracker;
  int unsigned tbl_len;
  int unsigned tap;
  logic [lxsr_pkg::WORD_W-1:0] seed_reg;
  logic [lxsr_pkg::WORD_W-1:0] word_mem [256];
  int unsigned ptr;
  logic [lxsr_pkg::WORD_W-1:0] lehmer_word;
  lxsr_pkg::lxsr_result_t pending_draws[$];
  int unsigned errors;

  function new(int unsigned len, int unsigned offset);
    tbl_len = len;
    tap = offset;
    seed_reg = lxsr_pkg::SEED_RESET;
    ptr = 0;
    lehmer_word = '0;
    errors = 0;
    for (int i = 0; i < 256; i++) word_mem[i] = '0;
  endfunction

  function void set_seed(logic [lxsr_pkg::WORD_W-1:0] value);
    seed_reg = value;
  endfunction

  function int unsigned pending();
    return pending_draws.size();
  endfunction

  function void note_item(lxsr_pkg::lxsr_item_t it);
    logic [61:0] prod;
    int unsigned q;
    lxsr_pkg::lxsr_result_t res;
    if (it.func == lxsr_pkg::FUNC_RESEED) begin
      lehmer_word = seed_reg;
      for (int i = 0; i < tbl_len; i++) begin
        prod = {31'b0, lehmer_word} * 62'(lxsr_pkg::LEHMER_MULT);
        lehmer_word = prod[30:0];
        word_mem[i] = lehmer_word;
      end
      ptr = 0;
    end else begin
      q = (ptr + tap) % tbl_len;
      res.random_word = word_mem[ptr] ^ word_mem[q];
      word_mem[ptr] = res.random_word;
      ptr = (ptr + 1) % tbl_len;
      prod = {31'b0, res.random_word} * {31'b0, it.scale_limit};
      res.scaled_value = prod[61:31];
      pending_draws.push_back(res);
    end
  endfunction

  function void check_result(lxsr_pkg::lxsr_result_t got);
    lxsr_pkg::lxsr_result_t exp_res;
    if (pending_draws.size() == 0) begin
      $error("result with no draw outstanding: random_word %0d scaled_value %0d",
             got.random_word, got.scaled_value);
      errors++;
      return;
    end
    exp_res = pending_draws.pop_front();
    if (got.random_word !== exp_res.random_word) begin
      $error("random_word: expected %0d, actual %0d", exp_res.random_word, got.random_word);
      errors++;
    end
    if (got.scaled_value !== exp_res.scaled_value) begin
      $error("scaled_value: expected %0d, actual %0d", exp_res.scaled_value,
             got.scaled_value);
      errors++;
    end
  endfunction
endclass

module lagged_xor_shift_register_rng_test;
  import lxsr_pkg::*;

  localparam int TBL_LEN        = 251;
  localparam int TAP            = 147;
  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 175;
  localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  lxsr_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  lxsr_result_t result;
  logic seed_wr_en = 1'b0;
  logic [WORD_W-1:0] seed_wr_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  gfsr_tracker sb = new(TBL_LEN, TAP);

  lagged_xor_shift_register_rng #(
    .TABLE_LENGTH(TBL_LEN),
    .TAP_OFFSET  (TAP)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .seed_wr_en  (seed_wr_en),
    .seed_wr_data(seed_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(result);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [WORD_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return WORD_MAX;
      2: return WORD_W'($urandom_range(1, 255));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // enter and leave at a falling edge
  task automatic send_item(input logic func, input logic [WORD_W-1:0] limit);
    lxsr_item_t it;
    it.func = func;
    it.scale_limit = limit;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // hold off long enough for a reseed to finish
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] value);
    settle();
    seed_wr_en <= 1'b1;
    seed_wr_data <= value;
    @(negedge clk);
    sb.set_seed(value);
    seed_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [WORD_W-1:0] seed_val, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    write_seed(seed_val);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    send_item(FUNC_RESEED, pick_limit());
    for (int i = 1; i < PHASE_ITEMS; i++) begin
      if (i == PHASE_ITEMS / 2) drain_results();
      if ($urandom_range(0, 99) < 2) send_item(FUNC_RESEED, pick_limit());
      else send_item(FUNC_DRAW, pick_limit());
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset seed, limits at both ends and alternating bits
    send_item(FUNC_RESEED, WORD_MAX);
    send_item(FUNC_DRAW, '0);
    send_item(FUNC_DRAW, WORD_MAX);
    send_item(FUNC_DRAW, 31'd1);
    send_item(FUNC_DRAW, 31'h4000_0000);
    send_item(FUNC_DRAW, 31'h5555_5555);
    send_item(FUNC_DRAW, 31'h2AAA_AAAA);

    // zero seed keeps every word at zero
    write_seed('0);
    send_item(FUNC_RESEED, '0);
    send_item(FUNC_DRAW, WORD_MAX);
    send_item(FUNC_DRAW, WORD_MAX);

    write_seed(WORD_MAX);
    send_item(FUNC_RESEED, 31'h5555_5555);
    send_item(FUNC_DRAW, WORD_MAX);
    send_item(FUNC_DRAW, '0);
    send_item(FUNC_DRAW, 31'h2AAA_AAAA);
    send_item(FUNC_RESEED, '0);
    send_item(FUNC_RESEED, WORD_MAX);
    send_item(FUNC_DRAW, WORD_MAX);
    send_item(FUNC_DRAW, 31'd2);

    run_phase(WORD_W'($urandom), 0, 0);
    run_phase(WORD_MAX, 80, 0);
    run_phase(WORD_W'($urandom_range(1, 1000)), 0, 80);
    run_phase(WORD_W'($urandom), 26, 26);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
